@@ rtl/tra_pkg.sv @@
package tra_pkg;

    // Register ALU opcodes. ADC, SBC, NEG and MUL are decoded but not executed.
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_LSL = 4'h2,
        OP_LSR = 4'h3,
        OP_ASR = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_ROR = 4'h7,
        OP_TST = 4'h8,
        OP_NEG = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MUL = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } t_opcode;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned SHAMT_W = 8;

    // One finished instruction
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              write_back;
        logic              flag_negative;
        logic              flag_zero;
        logic              flag_carry;
        logic              flag_overflow;
        logic              unsupported;
    } t_alu_result;

endpackage

@@ rtl/thumb_register_alu.sv @@
// Thumb register ALU (format 4 operations), one instruction per transaction.
//
// Input channel: i_in_valid with the opcode, both operand values and the
// current C and V flags; the block drives o_in_stall. A transaction is taken
// at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with the result, the write-back enable, the new
// N, Z, C, V flags and the unsupported flag; the receiver drives i_out_stall.
//
// The block is a two-register pipe: an input register, the ALU and barrel
// shifter as one combinational pass, then the result register. A transaction
// passes the input register, then the result register, to o_out_valid; the
// single ALU pass gives one transaction per cycle while i_out_stall is low.
//
// Reset (synchronous, active low) empties both registers. While i_out_stall
// holds a valid result, that result stays unchanged; the input register
// still fills if it is empty, and o_in_stall rises only when both registers
// hold transactions.
module thumb_register_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [3:0]                   i_mode,
    input  logic [tra_pkg::DATA_W-1:0]   i_first_value,
    input  logic [tra_pkg::DATA_W-1:0]   i_second_value,
    input  logic                         i_carry_in,
    input  logic                         i_overflow_in,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tra_pkg::DATA_W-1:0]   o_result_value,
    output logic                         o_write_back,
    output logic                         o_flag_negative,
    output logic                         o_flag_zero,
    output logic                         o_flag_carry,
    output logic                         o_flag_overflow,
    output logic                         o_unsupported
);

    localparam int unsigned W = tra_pkg::DATA_W;

    // Input register
    logic                 r_in_valid;
    tra_pkg::t_opcode     r_op;
    logic [W-1:0]         r_a;
    logic [W-1:0]         r_b;
    logic                 r_c;
    logic                 r_v;

    // Result register
    logic                 r_out_valid;
    tra_pkg::t_alu_result r_res;
    tra_pkg::t_alu_result n_res;

    logic out_load;
    logic in_load;

    // Advance the result register when it is empty or being drained
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_op <= tra_pkg::t_opcode'(i_mode);
            r_a  <= i_first_value;
            r_b  <= i_second_value;
            r_c  <= i_carry_in;
            r_v  <= i_overflow_in;
        end
    end

    // Shifter and adder intermediates
    logic [tra_pkg::SHAMT_W-1:0] shamt;
    logic [4:0]                  sh5;
    logic                        sh_zero;
    logic                        sh_eq32;
    logic                        sh_lt32;
    logic [W:0]                  lsl_ext;
    logic [W:0]                  lsr_ext;
    logic signed [W:0]           asr_ext;
    logic [2*W-1:0]              ror_ext;
    logic [W-1:0]                shift_res;
    logic                        shift_c;
    logic [W:0]                  diff;
    logic [W:0]                  sum;

    always_comb begin
        shamt   = r_b[tra_pkg::SHAMT_W-1:0];
        sh5     = shamt[4:0];
        sh_zero = (shamt == '0);
        sh_lt32 = (shamt[tra_pkg::SHAMT_W-1:5] == '0);
        sh_eq32 = (shamt == tra_pkg::SHAMT_W'(W));
        lsl_ext = {1'b0, r_a} << sh5;
        lsr_ext = {r_a, 1'b0} >> sh5;
        asr_ext = $signed({r_a, 1'b0}) >>> sh5;
        ror_ext = {r_a, r_a} >> sh5;
        diff    = {1'b0, r_a} - {1'b0, r_b};
        sum     = {1'b0, r_a} + {1'b0, r_b};

        // Barrel shifter with ARM carry-out rules
        shift_res = r_a;
        shift_c   = r_c;
        if (!sh_zero) begin
            unique case (r_op)
                tra_pkg::OP_LSL: begin
                    shift_res = sh_lt32 ? lsl_ext[W-1:0] : '0;
                    shift_c   = sh_lt32 ? lsl_ext[W] : (sh_eq32 & r_a[0]);
                end
                tra_pkg::OP_LSR: begin
                    shift_res = sh_lt32 ? lsr_ext[W:1] : '0;
                    shift_c   = sh_lt32 ? lsr_ext[0] : (sh_eq32 & r_a[W-1]);
                end
                tra_pkg::OP_ASR: begin
                    shift_res = sh_lt32 ? asr_ext[W:1] : {W{r_a[W-1]}};
                    shift_c   = sh_lt32 ? asr_ext[0] : r_a[W-1];
                end
                default: begin
                    shift_res = ror_ext[W-1:0];
                    shift_c   = ror_ext[W-1];
                end
            endcase
        end
    end

    // Select the operation and form the flags
    always_comb begin
        n_res               = '0;
        n_res.write_back    = 1'b1;
        n_res.flag_carry    = r_c;
        n_res.flag_overflow = r_v;
        unique case (r_op)
            tra_pkg::OP_AND: n_res.result_value = r_a & r_b;
            tra_pkg::OP_EOR: n_res.result_value = r_a ^ r_b;
            tra_pkg::OP_LSL,
            tra_pkg::OP_LSR,
            tra_pkg::OP_ASR,
            tra_pkg::OP_ROR: begin
                n_res.result_value = shift_res;
                n_res.flag_carry   = shift_c;
            end
            tra_pkg::OP_TST: begin
                n_res.result_value = r_a & r_b;
                n_res.write_back   = 1'b0;
            end
            tra_pkg::OP_CMP: begin
                n_res.result_value  = diff[W-1:0];
                n_res.flag_carry    = !diff[W];
                n_res.flag_overflow = (r_a[W-1] ^ r_b[W-1]) & (r_a[W-1] ^ diff[W-1]);
                n_res.write_back    = 1'b0;
            end
            tra_pkg::OP_CMN: begin
                n_res.result_value  = sum[W-1:0];
                n_res.flag_carry    = sum[W];
                n_res.flag_overflow = !(r_a[W-1] ^ r_b[W-1]) & (r_a[W-1] ^ sum[W-1]);
                n_res.write_back    = 1'b0;
            end
            tra_pkg::OP_ORR: n_res.result_value = r_a | r_b;
            tra_pkg::OP_BIC: n_res.result_value = r_a & ~r_b;
            tra_pkg::OP_MVN: n_res.result_value = ~r_b;
            tra_pkg::OP_ADC,
            tra_pkg::OP_SBC,
            tra_pkg::OP_NEG,
            tra_pkg::OP_MUL: begin
                n_res.write_back  = 1'b0;
                n_res.unsupported = 1'b1;
            end
        endcase
        if (!n_res.unsupported) begin
            n_res.flag_negative = n_res.result_value[W-1];
            n_res.flag_zero     = (n_res.result_value == '0);
        end
    end

    // Result register: load on advance, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_res.result_value;
    assign o_write_back    = r_res.write_back;
    assign o_flag_negative = r_res.flag_negative;
    assign o_flag_zero     = r_res.flag_zero;
    assign o_flag_carry    = r_res.flag_carry;
    assign o_flag_overflow = r_res.flag_overflow;
    assign o_unsupported   = r_res.unsupported;

    // Stall only when both registers are full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while pipe has room");

    // An accepted transaction lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted transaction not captured");

    // A filled input register moves to the output when the output drains
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !i_out_stall) |=> o_out_valid)
        else $error("transaction lost between stages");

    // Unsupported opcodes never write and carry a zero result
    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unsupported) |->
            (!o_write_back && o_result_value == '0 && !o_flag_zero && !o_flag_negative))
        else $error("unsupported opcode produced a result");

    // Zero flag tracks the result for executed opcodes
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_unsupported) |->
            (o_flag_zero == (o_result_value == '0)))
        else $error("zero flag does not match result");

endmodule

@@ sim/tb_thumb_register_alu.sv @@
module tb_thumb_register_alu;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected results of the register ALU, in issue order
    class alu_scoreboard;
        tra_pkg::t_alu_result expected_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Compute one format 4 instruction: value, write enable and NZCV
        function tra_pkg::t_alu_result predict_alu(tra_pkg::t_opcode op, logic [31:0] a,
                                                   logic [31:0] b, logic c, logic v);
            tra_pkg::t_alu_result res;
            logic [31:0] r;
            logic [31:0] ovf_bits;
            logic [32:0] sum;
            logic [7:0]  n;
            logic [4:0]  k;
            logic        wb;
            logic        uns;

            r   = '0;
            wb  = 1'b1;
            uns = 1'b0;
            n   = b[7:0];
            k   = n[4:0];
            case (op)
                tra_pkg::OP_AND: r = a & b;
                tra_pkg::OP_EOR: r = a ^ b;
                tra_pkg::OP_ORR: r = a | b;
                tra_pkg::OP_BIC: r = a & ~b;
                tra_pkg::OP_MVN: r = ~b;
                tra_pkg::OP_TST: begin
                    r  = a & b;
                    wb = 1'b0;
                end
                tra_pkg::OP_LSL: begin
                    if (n == 0) begin
                        r = a;
                    end else if (n < 32) begin
                        r = a << n;
                        c = a[32 - n];
                    end else begin
                        r = '0;
                        c = (n == 32) ? a[0] : 1'b0;
                    end
                end
                tra_pkg::OP_LSR: begin
                    if (n == 0) begin
                        r = a;
                    end else if (n < 32) begin
                        r = a >> n;
                        c = a[n - 1];
                    end else begin
                        r = '0;
                        c = (n == 32) ? a[31] : 1'b0;
                    end
                end
                tra_pkg::OP_ASR: begin
                    if (n == 0) begin
                        r = a;
                    end else if (n < 32) begin
                        r = $signed(a) >>> n;
                        c = a[n - 1];
                    end else begin
                        r = {32{a[31]}};
                        c = a[31];
                    end
                end
                tra_pkg::OP_ROR: begin
                    // a multiple of 32 leaves the value but still moves bit 31 to C
                    if (n == 0) begin
                        r = a;
                    end else begin
                        r = (k == 0) ? a : ((a >> k) | (a << (32 - k)));
                        c = r[31];
                    end
                end
                tra_pkg::OP_CMP: begin
                    r        = a - b;
                    c        = (a >= b);
                    ovf_bits = (a ^ b) & (a ^ r);
                    v        = ovf_bits[31];
                    wb       = 1'b0;
                end
                tra_pkg::OP_CMN: begin
                    sum      = {1'b0, a} + {1'b0, b};
                    r        = sum[31:0];
                    c        = sum[32];
                    ovf_bits = ~(a ^ b) & (a ^ r);
                    v        = ovf_bits[31];
                    wb       = 1'b0;
                end
                default: begin
                    uns = 1'b1;
                    wb  = 1'b0;
                end
            endcase
            res.result_value  = r;
            res.write_back    = wb;
            res.flag_negative = uns ? 1'b0 : r[31];
            res.flag_zero     = uns ? 1'b0 : (r == 0);
            res.flag_carry    = c;
            res.flag_overflow = v;
            res.unsupported   = uns;
            return res;
        endfunction

        function void note_instruction(tra_pkg::t_opcode op, logic [31:0] a, logic [31:0] b,
                                       logic c, logic v);
            expected_q.push_back(predict_alu(op, a, b, c, v));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        endtask

        // Compare one accepted result against the oldest expectation
        task check_result(tra_pkg::t_alu_result got);
            tra_pkg::t_alu_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", got.result_value, 32'h0);
            end else begin
                want = expected_q.pop_front();
                if (got.result_value !== want.result_value)
                    report_mismatch("result_value", got.result_value, want.result_value);
                if (got.write_back !== want.write_back)
                    report_mismatch("write_back", 32'(got.write_back),
                                    32'(want.write_back));
                if (got.flag_negative !== want.flag_negative)
                    report_mismatch("flag_negative", 32'(got.flag_negative),
                                    32'(want.flag_negative));
                if (got.flag_zero !== want.flag_zero)
                    report_mismatch("flag_zero", 32'(got.flag_zero),
                                    32'(want.flag_zero));
                if (got.flag_carry !== want.flag_carry)
                    report_mismatch("flag_carry", 32'(got.flag_carry),
                                    32'(want.flag_carry));
                if (got.flag_overflow !== want.flag_overflow)
                    report_mismatch("flag_overflow", 32'(got.flag_overflow),
                                    32'(want.flag_overflow));
                if (got.unsupported !== want.unsupported)
                    report_mismatch("unsupported", 32'(got.unsupported),
                                    32'(want.unsupported));
            end
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [3:0]  i_mode         = 4'h0;
    logic [31:0] i_first_value  = 32'h0;
    logic [31:0] i_second_value = 32'h0;
    logic        i_carry_in     = 1'b0;
    logic        i_overflow_in  = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_result_value;
    logic        o_write_back;
    logic        o_flag_negative;
    logic        o_flag_zero;
    logic        o_flag_carry;
    logic        o_flag_overflow;
    logic        o_unsupported;

    // No idling on either side once set
    logic        quiet_tail = 1'b0;

    alu_scoreboard sb = new();

    thumb_register_alu dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_carry_in     (i_carry_in),
        .i_overflow_in  (i_overflow_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_write_back   (o_write_back),
        .o_flag_negative(o_flag_negative),
        .o_flag_zero    (o_flag_zero),
        .o_flag_carry   (o_flag_carry),
        .o_flag_overflow(o_flag_overflow),
        .o_unsupported  (o_unsupported)
    );

    always #10 i_clk = ~i_clk;

    // Record accepted instructions and check accepted results
    always @(posedge i_clk) begin : monitor
        tra_pkg::t_alu_result seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_instruction(tra_pkg::t_opcode'(i_mode), i_first_value, i_second_value,
                                    i_carry_in, i_overflow_in);
            if (o_out_valid && !i_out_stall) begin
                seen.result_value  = o_result_value;
                seen.write_back    = o_write_back;
                seen.flag_negative = o_flag_negative;
                seen.flag_zero     = o_flag_zero;
                seen.flag_carry    = o_flag_carry;
                seen.flag_overflow = o_flag_overflow;
                seen.unsupported   = o_unsupported;
                sb.check_result(seen);
            end
        end
    end

    // Receiver backpressure: random stall and ready bursts, none in the tail
    initial begin : out_stall_gen
        int  run;
        logic level;
        forever begin
            if (quiet_tail) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                level = ($urandom_range(0, 2) == 0);
                run   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
                if (run > 12)
                    level = 1'b0;
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall <= level;
                end
            end
        end
    end

    // Present one instruction and hold it until the block takes it
    task automatic send_instruction(input tra_pkg::t_opcode op, input logic [31:0] a,
                                    input logic [31:0] b, input logic c, input logic v);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_mode         <= op;
        i_first_value  <= a;
        i_second_value <= b;
        i_carry_in     <= c;
        i_overflow_in  <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Shift source: mostly amounts near the 32 boundary, random upper bits
    function automatic logic [31:0] pick_shift_source();
        logic [31:0] upper;
        logic [7:0]  amt;
        upper = $urandom();
        case ($urandom_range(0, 3))
            0, 1: amt = 8'($urandom_range(0, 40));
            2: amt = {3'($urandom_range(0, 7)), 5'd0};
            default: amt = 8'($urandom_range(0, 255));
        endcase
        return {upper[31:8], amt};
    endfunction

    initial begin : stimulus
        tra_pkg::t_opcode op;
        logic [31:0] a;
        logic [31:0] b;
        int          w;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: logic ops, unsupported codes, shift edges, compare edges
        send_instruction(tra_pkg::OP_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_instruction(tra_pkg::OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_BIC, 32'hF0F0_F0F0, 32'h3C3C_3C3C, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_MVN, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_TST, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_ADC, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_SBC, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b1);
        send_instruction(tra_pkg::OP_NEG, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_MUL, 32'h0000_0003, 32'h0000_0005, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_LSL, 32'h8000_0001, 32'hFFFF_FF00, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0001, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_LSL, 32'h0000_0003, 32'h0000_001F, 1'b0, 1'b1);
        send_instruction(tra_pkg::OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_LSL, 32'hFFFF_FFFF, 32'h0000_0021, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_LSR, 32'hFFFF_FFFF, 32'h0000_00FF, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_ASR, 32'h8000_0000, 32'h0000_001F, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_ASR, 32'h8000_0000, 32'h0000_0028, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_ASR, 32'h7FFF_FFFF, 32'h0000_0020, 1'b1, 1'b0);
        send_instruction(tra_pkg::OP_ROR, 32'h8000_0001, 32'h0000_0020, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_ROR, 32'h0000_0010, 32'h0000_0044, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_CMP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1);
        send_instruction(tra_pkg::OP_CMP, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0);
        send_instruction(tra_pkg::OP_CMP, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1);
        send_instruction(tra_pkg::OP_CMN, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1);
        send_instruction(tra_pkg::OP_CMN, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);

        drain_results();

        // Random instructions with sender gaps; quiet tail at the end
        for (int i = 0; i < 1925; i++) begin
            if (i == 1700)
                quiet_tail = 1'b1;
            if (i == 900)
                drain_results();
            if (!quiet_tail && $urandom_range(0, 7) == 0)
                idle_input($urandom_range(1, 12));
            op = tra_pkg::t_opcode'($urandom_range(0, 15));
            a  = pick_operand();
            if ((op == tra_pkg::OP_LSL || op == tra_pkg::OP_LSR ||
                 op == tra_pkg::OP_ASR || op == tra_pkg::OP_ROR) && $urandom_range(0, 4) != 0)
                b = pick_shift_source();
            else if ((op == tra_pkg::OP_CMP || op == tra_pkg::OP_CMN)
                     && $urandom_range(0, 5) == 0)
                b = (op == tra_pkg::OP_CMP) ? a : -a;
            else
                b = pick_operand();
            send_instruction(op, a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for outstanding results, then let the pipe settle
        for (w = 0; w < 5000 && sb.pending() != 0; w++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results never returned", sb.pending(), 32'h0);

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tra_pkg.sv
rtl/thumb_register_alu.sv
sim/tb_thumb_register_alu.sv
